// ----- rtl/core/olt_pkg.sv -----
`default_nettype none

package olt_pkg;

  localparam int VAL_W = 32;
  localparam int POS_W = 7;
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;

  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0,
    REQ_DELETE = 3'd1,
    REQ_DELALL = 3'd2,
    REQ_SEARCH = 3'd3,
    REQ_READ   = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2
  } state_t;

  typedef struct packed {
    logic [2:0]              req_type;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    status_t                 status;
    logic [IDX_W-1:0]        found_index;
    logic signed [VAL_W-1:0] read_value;
    logic [CNT_W-1:0]        removed_count;
    logic [CNT_W-1:0]        element_count;
  } out_t;

endpackage

`default_nettype wire

// ----- rtl/core/olt_ram.sv -----
`default_nettype none

module olt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/olt_seq.sv -----
`default_nettype none

module olt_seq #(
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire olt_pkg::in_t             in_data,
  output logic                          res_valid,
  input  wire logic                     res_ready,
  output olt_pkg::out_t                 res_data,
  output logic                          mem_re,
  output logic [AW-1:0]                 mem_raddr,
  input  wire logic [olt_pkg::VAL_W-1:0] mem_rdata,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic [olt_pkg::VAL_W-1:0]     mem_wdata
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > olt_pkg::POS_W) ? CW : olt_pkg::POS_W;

  olt_pkg::state_t  state_r, state_nxt;
  logic [2:0]       op_r, op_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [olt_pkg::VAL_W-1:0] val_r, val_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    ridx_r, ridx_nxt;
  logic [CW-1:0]    rem_r, rem_nxt;
  logic [CW-1:0]    widx_r, widx_nxt;
  logic             pv_r, pv_nxt;
  logic [AW-1:0]    paddr_r, paddr_nxt;
  olt_pkg::status_t status_r, status_nxt;
  logic [AW-1:0]    fidx_r, fidx_nxt;
  logic [olt_pkg::VAL_W-1:0] rval_r, rval_nxt;
  logic [CW-1:0]    removed_r, removed_nxt;

  logic [XW-1:0]    pos_x;
  logic [XW-1:0]    cnt_x;
  logic [XW-1:0]    fidx_x;
  logic [XW-1:0]    removed_x;
  logic             pos_above;
  logic             pos_at_or_above;
  logic             full;
  logic             start_scan;
  logic             scan_end;

  assign pos_x           = XW'(in_data.position);
  assign cnt_x           = XW'(cnt_r);
  assign pos_above       = pos_x > cnt_x;
  assign pos_at_or_above = pos_x >= cnt_x;
  assign full            = cnt_x == XW'(DEPTH);
  assign scan_end        = (rem_r == '0) && !pv_r;

  always_comb begin
    case (in_data.req_type)
      olt_pkg::REQ_INSERT: start_scan = !pos_above && !full;
      olt_pkg::REQ_DELETE: start_scan = !pos_at_or_above;
      olt_pkg::REQ_DELALL: start_scan = 1'b1;
      olt_pkg::REQ_SEARCH: start_scan = 1'b1;
      olt_pkg::REQ_READ:   start_scan = !pos_at_or_above;
      default:             start_scan = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      olt_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = start_scan ? olt_pkg::S_SCAN : olt_pkg::S_DONE;
        end
      end
      olt_pkg::S_SCAN: begin
        if (scan_end) begin
          state_nxt = olt_pkg::S_DONE;
        end
      end
      olt_pkg::S_DONE: begin
        if (res_ready) begin
          state_nxt = olt_pkg::S_IDLE;
        end
      end
      default: state_nxt = olt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op_nxt      = op_r;
    pos_nxt     = pos_r;
    val_nxt     = val_r;
    cnt_nxt     = cnt_r;
    ridx_nxt    = ridx_r;
    rem_nxt     = rem_r;
    widx_nxt    = widx_r;
    pv_nxt      = 1'b0;
    paddr_nxt   = paddr_r;
    status_nxt  = status_r;
    fidx_nxt    = fidx_r;
    rval_nxt    = rval_r;
    removed_nxt = removed_r;
    mem_re      = 1'b0;
    mem_raddr   = ridx_r[AW-1:0];
    mem_we      = 1'b0;
    mem_waddr   = paddr_r;
    mem_wdata   = mem_rdata;
    case (state_r)
      olt_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_data.req_type;
          pos_nxt     = pos_x[AW-1:0];
          val_nxt     = in_data.value;
          status_nxt  = olt_pkg::ST_OK;
          fidx_nxt    = '0;
          rval_nxt    = '0;
          removed_nxt = '0;
          widx_nxt    = '0;
          rem_nxt     = '0;
          ridx_nxt    = '0;
          case (in_data.req_type)
            olt_pkg::REQ_INSERT: begin
              if (pos_above) begin
                status_nxt = olt_pkg::ST_BADPOS;
              end else if (full) begin
                status_nxt = olt_pkg::ST_FULL;
              end else begin
                rem_nxt  = CW'(cnt_x - pos_x);
                ridx_nxt = cnt_r - 1'b1;
              end
            end
            olt_pkg::REQ_DELETE: begin
              if (pos_at_or_above) begin
                status_nxt = olt_pkg::ST_BADPOS;
              end else begin
                rem_nxt  = CW'(cnt_x - pos_x - 1'b1);
                ridx_nxt = CW'(pos_x + 1'b1);
              end
            end
            olt_pkg::REQ_DELALL: begin
              rem_nxt = cnt_r;
            end
            olt_pkg::REQ_SEARCH: begin
              status_nxt = olt_pkg::ST_NOTFOUND;
              rem_nxt    = cnt_r;
            end
            olt_pkg::REQ_READ: begin
              if (pos_at_or_above) begin
                status_nxt = olt_pkg::ST_BADPOS;
              end else begin
                rem_nxt  = CW'(1);
                ridx_nxt = CW'(pos_x);
              end
            end
            default: begin
              status_nxt = olt_pkg::ST_OK;
            end
          endcase
        end
      end
      olt_pkg::S_SCAN: begin
        if (rem_r != '0) begin
          mem_re    = 1'b1;
          paddr_nxt = ridx_r[AW-1:0];
          pv_nxt    = 1'b1;
          rem_nxt   = rem_r - 1'b1;
          ridx_nxt  = (op_r == olt_pkg::REQ_INSERT) ? ridx_r - 1'b1 : ridx_r + 1'b1;
        end
        if (pv_r) begin
          case (op_r)
            olt_pkg::REQ_INSERT: begin
              mem_we    = 1'b1;
              mem_waddr = paddr_r + 1'b1;
            end
            olt_pkg::REQ_DELETE: begin
              mem_we    = 1'b1;
              mem_waddr = paddr_r - 1'b1;
            end
            olt_pkg::REQ_DELALL: begin
              if (mem_rdata != val_r) begin
                mem_we    = 1'b1;
                mem_waddr = widx_r[AW-1:0];
                widx_nxt  = widx_r + 1'b1;
              end
            end
            olt_pkg::REQ_SEARCH: begin
              if ((mem_rdata == val_r) && (status_r == olt_pkg::ST_NOTFOUND)) begin
                status_nxt = olt_pkg::ST_OK;
                fidx_nxt   = paddr_r;
              end
            end
            olt_pkg::REQ_READ: begin
              rval_nxt = mem_rdata;
            end
            default: begin
              rval_nxt = rval_r;
            end
          endcase
        end
        if (scan_end) begin
          case (op_r)
            olt_pkg::REQ_INSERT: begin
              mem_we    = 1'b1;
              mem_waddr = pos_r;
              mem_wdata = val_r;
              cnt_nxt   = cnt_r + 1'b1;
            end
            olt_pkg::REQ_DELETE: begin
              cnt_nxt     = cnt_r - 1'b1;
              removed_nxt = CW'(1);
            end
            olt_pkg::REQ_DELALL: begin
              removed_nxt = cnt_r - widx_r;
              cnt_nxt     = widx_r;
            end
            default: begin
              cnt_nxt = cnt_r;
            end
          endcase
        end
      end
      default: begin
        pv_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= olt_pkg::S_IDLE;
      cnt_r   <= '0;
      pv_r    <= 1'b0;
      rem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pv_r    <= pv_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    pos_r     <= pos_nxt;
    val_r     <= val_nxt;
    ridx_r    <= ridx_nxt;
    widx_r    <= widx_nxt;
    paddr_r   <= paddr_nxt;
    status_r  <= status_nxt;
    fidx_r    <= fidx_nxt;
    rval_r    <= rval_nxt;
    removed_r <= removed_nxt;
  end

  assign fidx_x    = XW'(fidx_r);
  assign removed_x = XW'(removed_r);

  assign in_ready  = state_r == olt_pkg::S_IDLE;
  assign res_valid = state_r == olt_pkg::S_DONE;

  always_comb begin
    res_data.status        = status_r;
    res_data.found_index   = fidx_x[olt_pkg::IDX_W-1:0];
    res_data.read_value    = rval_r;
    res_data.removed_count = removed_x[olt_pkg::CNT_W-1:0];
    res_data.element_count = cnt_x[olt_pkg::CNT_W-1:0];
  end

endmodule

`default_nettype wire

// ----- rtl/core/ordered_list_table.sv -----
// Ordered list of signed 32-bit words held in one single-port-read,
// single-port-write RAM, with a count of valid entries.
// Requests arrive as beats on in_valid/in_ready/in_data: insert at a
// position, delete at a position, delete every entry equal to a value,
// search for the first matching index, or read at a position. Every request
// returns exactly one beat on out_valid/out_ready/out_data with a status,
// the found index, the read word, the removed count and the new count.
// One request is worked at a time. The sequencer streams the affected
// entries through the RAM, at most one read and one write a cycle. The
// number of entries walked is count minus position for insert, count
// minus position minus one for delete, count for delete-all and search,
// and one for read. A rejected or unknown request skips the walk and goes
// straight to its result. No new request is accepted until the current
// one has handed its result to the output register.
// The result sits in an output register, so the next request is accepted
// while a finished result waits on a stalled out_ready.
// Synchronous reset empties the list; RAM contents are left as they are and
// are never read before they are written.
`default_nettype none

module ordered_list_table #(
  parameter int LIST_DEPTH = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire olt_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output olt_pkg::out_t      out_data
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic                      res_valid;
  logic                      res_ready;
  olt_pkg::out_t             res_data;
  logic                      mem_re;
  logic [AW-1:0]             mem_raddr;
  logic [olt_pkg::VAL_W-1:0] mem_rdata;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [olt_pkg::VAL_W-1:0] mem_wdata;
  logic                      out_valid_r, out_valid_nxt;
  olt_pkg::out_t             out_data_r, out_data_nxt;

  olt_seq #(
    .DEPTH (LIST_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata)
  );

  olt_ram #(
    .WIDTH (olt_pkg::VAL_W),
    .DEPTH (LIST_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !in_ready)
    else $error("RAM written while the sequencer is idle");

  a_one_request_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request accepted while one is in progress");

  a_miss_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == olt_pkg::ST_NOTFOUND)) |->
      ((out_data.found_index == '0) && (out_data.removed_count == '0)))
    else $error("search miss reports a nonzero index or removal");

  a_badpos_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == olt_pkg::ST_BADPOS)) |->
      ((out_data.read_value == '0) && (out_data.removed_count == '0)))
    else $error("bad position reports data or a removal");

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import olt_pkg::*;

  localparam int LIST_DEPTH  = 64;
  localparam int LIST_OPS    = 2000;
  localparam int HOLD_START  = 3000;
  localparam int HOLD_CYCLES = 500;
  localparam int DRAIN_TAIL  = LIST_DEPTH + 16;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int PRINT_LIMIT = 100;

  localparam int STYLE_GROW   = 0;
  localparam int STYLE_SHRINK = 1;
  localparam int STYLE_MIXED  = 2;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  ordered_list_table #(.LIST_DEPTH(LIST_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Shadow copy of the list, advanced as each request is queued.
  logic signed [VAL_W-1:0] list_words [LIST_DEPTH];
  int list_count;

  in_t  pending_reqs[$];
  out_t pending_resps[$];
  out_t expected_resps[$];

  logic [31:0] extreme_vals [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};

  int mismatch_count;
  int results_checked;
  int cycle_count;
  int list_ops;
  int unknown_ops;
  int peak_count;
  int kind_seen [5];
  int status_seen [4];

  logic in_taken;
  int   tx_gap;
  logic tx_calm;
  int   rx_stall;
  logic rx_calm;
  logic hold_rx;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_t list_apply(in_t req);
    out_t r;
    int pos;
    int w;
    int removed;
    r = '0;
    r.status = ST_OK;
    pos = int'(req.position);
    removed = 0;
    case (req.req_type)
      REQ_INSERT: begin
        if (pos > list_count) begin
          r.status = ST_BADPOS;
        end else if (list_count >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = list_count; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = req.value;
          list_count++;
        end
      end
      REQ_DELETE: begin
        if (pos >= list_count) begin
          r.status = ST_BADPOS;
        end else begin
          for (int i = pos; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
          list_count--;
          removed = 1;
        end
      end
      REQ_DELALL: begin
        w = 0;
        for (int i = 0; i < list_count; i++) begin
          if (list_words[i] != req.value) begin
            list_words[w] = list_words[i];
            w++;
          end
        end
        removed = list_count - w;
        list_count = w;
      end
      REQ_SEARCH: begin
        r.status = ST_NOTFOUND;
        for (int i = 0; i < list_count; i++) begin
          if (list_words[i] == req.value) begin
            r.status = ST_OK;
            r.found_index = IDX_W'(i);
            break;
          end
        end
      end
      REQ_READ: begin
        if (pos >= list_count) r.status = ST_BADPOS;
        else r.read_value = list_words[pos];
      end
      default: ;
    endcase
    r.removed_count = CNT_W'(removed);
    r.element_count = CNT_W'(list_count);
    return r;
  endfunction

  task automatic post_request(logic [2:0] kind, int pos, logic [31:0] val);
    in_t  req;
    out_t resp;
    req.req_type = kind;
    req.position = pos[POS_W-1:0];
    req.value    = val;
    resp = list_apply(req);
    pending_reqs.insert(pending_reqs.size(), req);
    pending_resps.insert(pending_resps.size(), resp);
    if (kind <= REQ_READ) begin
      list_ops++;
      kind_seen[kind]++;
    end else begin
      unknown_ops++;
    end
    status_seen[resp.status]++;
    if (list_count > peak_count) peak_count = list_count;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 32'($urandom_range(0, 6)) - 32'd3;
      4, 5, 6: begin
        if (list_count > 0) return list_words[$urandom_range(0, list_count - 1)];
        return 32'($urandom_range(0, 6)) - 32'd3;
      end
      7: return extreme_vals[$urandom_range(0, 3)];
      default: return $urandom();
    endcase
  endfunction

  function automatic int pick_pos(logic [2:0] kind);
    int top;
    top = (kind == REQ_INSERT) ? list_count : list_count - 1;
    if (top < 0 || $urandom_range(0, 9) == 0) return $urandom_range(top + 1, 127);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return top;
      default: return $urandom_range(0, top);
    endcase
  endfunction

  function automatic logic [2:0] pick_kind(int style);
    int r;
    r = $urandom_range(0, 99);
    if (r >= 98) return 3'($urandom_range(5, 7));
    case (style)
      STYLE_GROW: begin
        if (r < 65) return REQ_INSERT;
        if (r < 72) return REQ_DELETE;
        if (r < 76) return REQ_DELALL;
        if (r < 86) return REQ_SEARCH;
      end
      STYLE_SHRINK: begin
        if (r < 15) return REQ_INSERT;
        if (r < 55) return REQ_DELETE;
        if (r < 65) return REQ_DELALL;
        if (r < 80) return REQ_SEARCH;
      end
      default: begin
        if (r < 30) return REQ_INSERT;
        if (r < 50) return REQ_DELETE;
        if (r < 56) return REQ_DELALL;
        if (r < 76) return REQ_SEARCH;
      end
    endcase
    return REQ_READ;
  endfunction

  task automatic run_episode(int style, int n);
    logic [2:0] kind;
    for (int k = 0; k < n; k++) begin
      kind = pick_kind(style);
      post_request(kind, pick_pos(kind), pick_value());
    end
  endtask

  task automatic flag_mismatch(string msg);
    if (mismatch_count < PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                              results_checked, name, got, want));
  endtask

  // Input beat acceptance and result checking, both at the rising edge.
  always @(posedge clk) begin
    out_t want;
    in_taken = rst_n && in_valid && in_ready;
    if (in_taken) expected_resps.insert(expected_resps.size(), pending_resps.pop_front());
    if (rst_n && out_valid && out_ready) begin
      if (expected_resps.size() == 0) begin
        flag_mismatch($sformatf("result beat with no request outstanding: 0x%0h", out_data));
      end else begin
        want = expected_resps.pop_front();
        check_field("status", 32'(out_data.status), 32'(want.status));
        check_field("found_index", 32'(out_data.found_index), 32'(want.found_index));
        check_field("read_value", out_data.read_value, want.read_value);
        check_field("removed_count", 32'(out_data.removed_count), 32'(want.removed_count));
        check_field("element_count", 32'(out_data.element_count), 32'(want.element_count));
      end
      results_checked++;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (tx_gap > 0) begin
        tx_gap   <= tx_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_reqs.pop_front();
        tx_gap   <= tx_calm ? 0 : pick_gap();
        if ($urandom_range(0, 127) == 0) tx_calm <= !tx_calm;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || hold_rx) begin
      out_ready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall  <= rx_stall - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!rx_calm && $urandom_range(0, 3) == 0) rx_stall <= pick_gap();
      if ($urandom_range(0, 255) == 0) rx_calm <= !rx_calm;
    end
  end

  // Long receiver hold-off so the block backs up and stalls its input.
  initial begin
    hold_rx = 1'b0;
    @(posedge rst_n);
    repeat (HOLD_START) @(posedge clk);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
               pending_resps.size() + expected_resps.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    tx_gap    = 0;
    tx_calm   = 1'b0;
    rx_stall  = 0;
    rx_calm   = 1'b0;
    in_taken  = 1'b0;
    list_count = 0;

    // Empty list corner cases.
    post_request(REQ_DELETE, 0, 32'h0);
    post_request(REQ_READ, 0, 32'h0);
    post_request(REQ_SEARCH, 0, 32'h0);
    post_request(REQ_DELALL, 0, 32'h0);
    post_request(REQ_INSERT, 1, 32'd5);
    post_request(REQ_INSERT, 127, 32'hFFFF_FFFF);
    // Build a short list at the head, tail and middle.
    post_request(REQ_INSERT, 0, 32'h7FFF_FFFF);
    post_request(REQ_INSERT, 1, 32'h8000_0000);
    post_request(REQ_INSERT, 0, 32'hFFFF_FFFF);
    post_request(REQ_INSERT, 2, 32'h0);
    post_request(REQ_SEARCH, 0, 32'h8000_0000);
    post_request(REQ_SEARCH, 0, 32'h1234_5678);
    post_request(REQ_READ, 3, 32'h0);
    post_request(REQ_READ, 4, 32'h0);
    post_request(REQ_DELETE, 4, 32'h0);
    post_request(REQ_DELETE, 1, 32'h0);
    post_request(3'd5, 127, 32'hFFFF_FFFF);
    post_request(3'd6, 0, 32'h0);
    post_request(3'd7, 64, 32'hA5A5_5A5A);
    post_request(REQ_INSERT, 0, 32'd5);
    post_request(REQ_INSERT, 2, 32'd5);
    post_request(REQ_INSERT, 5, 32'd5);
    post_request(REQ_DELALL, 127, 32'd5);
    post_request(REQ_DELALL, 0, 32'h5555_5555);
    post_request(REQ_DELETE, 0, 32'h0);

    // Fill to capacity, then knock on the full list.
    while (list_count < LIST_DEPTH)
      post_request(REQ_INSERT, $urandom_range(0, list_count), pick_value());
    post_request(REQ_INSERT, 0, pick_value());
    post_request(REQ_INSERT, LIST_DEPTH, pick_value());
    post_request(REQ_SEARCH, 0, list_words[LIST_DEPTH-1]);
    post_request(REQ_READ, LIST_DEPTH - 1, 32'h0);

    while (list_ops < LIST_OPS)
      run_episode($urandom_range(STYLE_GROW, STYLE_MIXED), $urandom_range(40, 160));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() > 0 || pending_resps.size() > 0 || expected_resps.size() > 0)
      @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("Ran %0d list requests (%0d insert, %0d delete, %0d delete-all, %0d search, %0d read)",
             list_ops, kind_seen[REQ_INSERT], kind_seen[REQ_DELETE], kind_seen[REQ_DELALL],
             kind_seen[REQ_SEARCH], kind_seen[REQ_READ]);
    $display("and %0d unknown ones; %0d full rejects, %0d bad positions, %0d misses, peak %0d.",
             unknown_ops, status_seen[ST_FULL], status_seen[ST_BADPOS],
             status_seen[ST_NOTFOUND], peak_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches over %0d result beats.", mismatch_count, results_checked);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
